// ===== design/slsw_pkg.sv =====
`default_nettype none

package slsw_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_SHOW  = 2'd1;
   localparam logic [1:0] OP_CMD   = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam int DIGITS      = 4;
   localparam int FRAMES_SHOW = 7;
   localparam int CMD_LEN     = 12;
   localparam int SHOW_LEN    = 13;

   localparam int SEG_CODES = 13;

   // segment patterns for codes 0-9, C, blank, dash
   localparam logic [6:0] SEG_TABLE [SEG_CODES] = '{
      7'h7B, 7'h12, 7'h67, 7'h57, 7'h1E, 7'h5D, 7'h7D,
      7'h13, 7'h7F, 7'h5F, 7'h69, 7'h00, 7'h04
   };

   // segment bit carried by each address frame
   localparam logic [2:0] FRAME_SEG_BIT [FRAMES_SHOW] = '{
      3'd0, 3'd1, 3'd4, 3'd6, 3'd5, 3'd3, 3'd2
   };

   typedef logic [3:0] digit_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  frame;
      digit_type   [DIGITS-1:0] digits;
      logic [7:0]  command;
   } frame_ctx_type;

endpackage

`default_nettype wire

// ===== design/slsw_bit_gen.sv =====
`default_nettype none

module slsw_bit_gen #(
   parameter int POS_W = 9
) (
   input  wire slsw_pkg::frame_ctx_type ctx,
   input  wire logic [POS_W-1:0]        pos,
   output logic                         data_bit
);

   logic [3:0]  pos_lo;
   logic [5:0]  addr;
   logic [1:0]  digit_sel;
   logic [3:0]  code;
   logic [6:0]  seg;
   logic [2:0]  seg_bit;

   assign pos_lo    = pos[3:0];
   assign addr      = (ctx.kind == slsw_pkg::OP_SHOW) ? {3'b000, ctx.frame} : 6'd0;
   // pos 9 carries the fourth digit, pos 12 the first
   assign digit_sel = 2'(4'd12 - pos_lo);
   assign code      = ctx.digits[digit_sel];
   assign seg       = (code < 4'(slsw_pkg::SEG_CODES)) ? slsw_pkg::SEG_TABLE[code] : 7'd0;
   assign seg_bit   = (ctx.frame < 3'(slsw_pkg::FRAMES_SHOW)) ?
                      slsw_pkg::FRAME_SEG_BIT[ctx.frame] : 3'd0;

   always_comb begin
      data_bit = 1'b0;
      if (ctx.kind == slsw_pkg::OP_CMD) begin
         if (pos < POS_W'(4)) begin
            data_bit = (pos == POS_W'(0));
         end else if (pos < POS_W'(slsw_pkg::CMD_LEN)) begin
            data_bit = ctx.command[3'(4'd11 - pos_lo)];
         end
      end else begin
         if (pos < POS_W'(3)) begin
            data_bit = (pos != POS_W'(1));
         end else if (pos < POS_W'(9)) begin
            data_bit = addr[3'(4'd8 - pos_lo)];
         end else if (ctx.kind == slsw_pkg::OP_SHOW && pos < POS_W'(slsw_pkg::SHOW_LEN)
                      && ctx.frame < 3'(slsw_pkg::FRAMES_SHOW)) begin
            data_bit = seg[seg_bit];
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/segment_lcd_serial_writer.sv =====
`default_nettype none

// Three-wire LCD write sequencer. A show, command or clear request latches its
// operands; each following tick item moves the pins by one half-bit (clock low
// with data, then clock high) and ends each frame with one tick raising chip
// select. Every item, request or tick, yields exactly one result carrying the
// pin levels after it. Unless a result waits untaken, one item is taken per
// clock: the state update and the result register load happen on the same edge,
// and req_ready stays high while a waiting result is taken. A show transfer is 7
// frames of 13 bits (189 ticks), a command 25 ticks, a clear 2*(9+8*CLEAR_BYTES)+1 ticks.
module segment_lcd_serial_writer #(
   parameter int CLEAR_BYTES = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_op,
   input  wire logic [3:0] req_digit_first,
   input  wire logic [3:0] req_digit_second,
   input  wire logic [3:0] req_digit_third,
   input  wire logic [3:0] req_digit_fourth,
   input  wire logic [7:0] req_command_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_chip_select_n,
   output logic            rsp_write_clock,
   output logic            rsp_serial_data,
   output logic            rsp_busy_res,
   output logic            rsp_refused,
   output logic            rsp_done_res
);

   localparam int CLEAR_LEN = 9 + 8 * CLEAR_BYTES;
   localparam int POS_W     = $clog2(CLEAR_LEN + 1);

   logic                    active_ff, active_in;
   slsw_pkg::frame_ctx_type ctx_ff, ctx_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    phase_ff, phase_in;
   logic                    cs_ff, cs_in;
   logic                    wr_ff, wr_in;
   logic                    data_ff, data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    refused_ff, refused_in;
   logic                    done_ff, done_in;

   logic                    accept;
   logic                    data_bit;
   logic [POS_W-1:0]        frame_len;
   logic [2:0]              frame_next;
   logic [2:0]              frame_total;

   slsw_bit_gen #(.POS_W(POS_W)) u_bit_gen (
      .ctx      (ctx_ff),
      .pos      (pos_ff),
      .data_bit (data_bit)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      unique case (ctx_ff.kind)
         slsw_pkg::OP_CMD:  frame_len = POS_W'(slsw_pkg::CMD_LEN);
         slsw_pkg::OP_SHOW: frame_len = POS_W'(slsw_pkg::SHOW_LEN);
         default:           frame_len = POS_W'(CLEAR_LEN);
      endcase
   end

   assign frame_total = (ctx_ff.kind == slsw_pkg::OP_SHOW) ?
                        3'(slsw_pkg::FRAMES_SHOW) : 3'd1;
   assign frame_next  = ctx_ff.frame + 3'd1;

   always_comb begin
      active_in    = active_ff;
      ctx_in       = ctx_ff;
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      cs_in        = cs_ff;
      wr_in        = wr_ff;
      data_in      = data_ff;
      refused_in   = refused_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         refused_in   = 1'b0;
         done_in      = 1'b0;
         if (req_op != slsw_pkg::OP_TICK) begin
            if (active_ff) begin
               refused_in = 1'b1;
            end else begin
               active_in         = 1'b1;
               ctx_in.kind       = req_op;
               ctx_in.frame      = 3'd0;
               ctx_in.digits[0]  = req_digit_first;
               ctx_in.digits[1]  = req_digit_second;
               ctx_in.digits[2]  = req_digit_third;
               ctx_in.digits[3]  = req_digit_fourth;
               ctx_in.command    = req_command_byte;
               pos_in            = '0;
               phase_in          = 1'b0;
            end
         end else if (active_ff) begin
            priority if (pos_ff >= frame_len) begin
               // end of frame: raise select, move to next frame or finish the transfer
               cs_in        = 1'b1;
               ctx_in.frame = frame_next;
               pos_in       = '0;
               phase_in     = 1'b0;
               if (frame_next >= frame_total) begin
                  active_in    = 1'b0;
                  ctx_in.frame = 3'd0;
                  done_in      = 1'b1;
               end
            end else if (!phase_ff) begin
               cs_in    = 1'b0;
               wr_in    = 1'b0;
               data_in  = data_bit;
               phase_in = 1'b1;
            end else begin
               wr_in    = 1'b1;
               phase_in = 1'b0;
               pos_in   = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         ctx_ff       <= '0;
         pos_ff       <= '0;
         phase_ff     <= 1'b0;
         cs_ff        <= 1'b1;
         wr_ff        <= 1'b1;
         data_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         refused_ff   <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         active_ff    <= active_in;
         ctx_ff       <= ctx_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         cs_ff        <= cs_in;
         wr_ff        <= wr_in;
         data_ff      <= data_in;
         rsp_valid_ff <= rsp_valid_in;
         refused_ff   <= refused_in;
         done_ff      <= done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chip_select_n = cs_ff;
   assign rsp_write_clock   = wr_ff;
   assign rsp_serial_data   = data_ff;
   assign rsp_busy_res      = active_ff;
   assign rsp_refused       = refused_ff;
   assign rsp_done_res      = done_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !active_ff)
      else $error("done flagged while transfer still active");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && refused_ff))
      else $error("done and refused in the same item");

   a_high_phase_selected: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!cs_ff && !wr_ff && active_ff))
      else $error("clock low phase outside a selected frame");

   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (ctx_ff.frame == 3'd0 && pos_ff == '0))
      else $error("frame counters not cleared while idle");

   a_refused_no_change: assert property (@(posedge clock) disable iff (reset)
      (accept && active_ff && req_op != slsw_pkg::OP_TICK) |=>
      ($stable(ctx_ff) && $stable(pos_ff) && refused_ff))
      else $error("refused request altered transfer state");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLEAR_N      = 16;
   localparam int TOTAL_ITEMS  = 1250;
   localparam int QUIET_LIMIT  = 2000;
   localparam int ROWS         = 26;

   // own copy of the glyphs (codes 0-9, C, blank, dash) and per-frame segment masks
   localparam logic [6:0] GLYPHS [13] = '{
      7'h7B, 7'h12, 7'h67, 7'h57, 7'h1E, 7'h5D, 7'h7D,
      7'h13, 7'h7F, 7'h5F, 7'h69, 7'h00, 7'h04
   };
   localparam logic [6:0] FRAME_MASK [slsw_pkg::FRAMES_SHOW] = '{
      7'h01, 7'h02, 7'h10, 7'h40, 7'h20, 7'h08, 7'h04
   };

   typedef struct packed {
      logic cs_n;
      logic wr_clk;
      logic sdata;
      logic busy;
      logic refused;
      logic done;
   } pin_result_type;

   typedef struct {
      logic [1:0]          op;
      slsw_pkg::digit_type first;
      slsw_pkg::digit_type second;
      slsw_pkg::digit_type third;
      slsw_pkg::digit_type fourth;
      logic [7:0]          cmd;
      int                  reps;
      bit                  typed;
      pin_result_type      want;
   } stim_row_type;

   typedef enum {SINK_OPEN, SINK_THIRDS, SINK_COIN, SINK_BLOCKS} sink_mode_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_op = slsw_pkg::OP_TICK;
   slsw_pkg::digit_type req_digit_first = '0;
   slsw_pkg::digit_type req_digit_second = '0;
   slsw_pkg::digit_type req_digit_third = '0;
   slsw_pkg::digit_type req_digit_fourth = '0;
   logic [7:0]          req_command_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_chip_select_n;
   logic                rsp_write_clock;
   logic                rsp_serial_data;
   logic                rsp_busy_res;
   logic                rsp_refused;
   logic                rsp_done_res;

   segment_lcd_serial_writer #(.CLEAR_BYTES(CLEAR_N)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_digit_first   (req_digit_first),
      .req_digit_second  (req_digit_second),
      .req_digit_third   (req_digit_third),
      .req_digit_fourth  (req_digit_fourth),
      .req_command_byte  (req_command_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chip_select_n (rsp_chip_select_n),
      .rsp_write_clock   (rsp_write_clock),
      .rsp_serial_data   (rsp_serial_data),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_refused       (rsp_refused),
      .rsp_done_res      (rsp_done_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   logic                lcd_busy = 1'b0;
   logic [1:0]          lcd_kind = slsw_pkg::OP_TICK;
   logic [2:0]          lcd_frame = '0;
   logic [15:0]         lcd_bit = '0;
   logic                lcd_half = 1'b0;
   slsw_pkg::digit_type lcd_digits [slsw_pkg::DIGITS] = '{default: '0};
   logic [7:0]          lcd_cmd = '0;
   logic                pin_cs = 1'b1;
   logic                pin_wr = 1'b1;
   logic                pin_sd = 1'b0;

   pin_result_type pending_pins [$];

   function automatic int frame_bits(input logic [1:0] kind);
      if (kind == slsw_pkg::OP_CMD) return slsw_pkg::CMD_LEN;
      if (kind == slsw_pkg::OP_SHOW) return slsw_pkg::SHOW_LEN;
      return 9 + 8 * CLEAR_N;
   endfunction

   function automatic int frames_in(input logic [1:0] kind);
      return (kind == slsw_pkg::OP_SHOW) ? slsw_pkg::FRAMES_SHOW : 1;
   endfunction

   // ticks from the request to the one that reports done
   function automatic int transfer_ticks(input logic [1:0] kind);
      return frames_in(kind) * (2 * frame_bits(kind) + 1);
   endfunction

   function automatic logic [6:0] glyph(input slsw_pkg::digit_type code);
      return (code <= 4'd12) ? GLYPHS[code] : 7'h00;
   endfunction

   function automatic logic frame_bit(input logic [15:0] pos);
      logic [5:0] addr;
      addr = (lcd_kind == slsw_pkg::OP_SHOW) ? {3'b000, lcd_frame} : 6'd0;
      if (lcd_kind == slsw_pkg::OP_CMD) begin
         if (pos < 4) return pos == 0;
         if (pos < 12) return lcd_cmd[3'(11 - pos)];
         return 1'b0;
      end
      if (pos < 3) return pos != 1;
      if (pos < 9) return addr[3'(8 - pos)];
      // segment bits go out fourth digit first
      if (lcd_kind == slsw_pkg::OP_SHOW && pos < 13)
         return |(glyph(lcd_digits[2'(12 - pos)]) & FRAME_MASK[lcd_frame]);
      return 1'b0;
   endfunction

   function automatic pin_result_type predict_pins(input logic [1:0] op,
         input slsw_pkg::digit_type f, input slsw_pkg::digit_type s,
         input slsw_pkg::digit_type t, input slsw_pkg::digit_type u,
         input logic [7:0] cmd);
      logic refused;
      logic done;
      refused = 1'b0;
      done = 1'b0;
      if (op != slsw_pkg::OP_TICK) begin
         if (lcd_busy) begin
            refused = 1'b1;
         end else begin
            lcd_busy = 1'b1;
            lcd_kind = op;
            lcd_frame = '0;
            lcd_bit = '0;
            lcd_half = 1'b0;
            lcd_digits = '{f, s, t, u};
            lcd_cmd = cmd;
         end
      end else if (lcd_busy) begin
         if (lcd_bit >= frame_bits(lcd_kind)) begin
            pin_cs = 1'b1;
            lcd_frame = lcd_frame + 3'd1;
            lcd_bit = '0;
            lcd_half = 1'b0;
            if (lcd_frame >= frames_in(lcd_kind)) begin
               lcd_busy = 1'b0;
               lcd_frame = '0;
               done = 1'b1;
            end
         end else if (!lcd_half) begin
            pin_cs = 1'b0;
            pin_wr = 1'b0;
            pin_sd = frame_bit(lcd_bit);
            lcd_half = 1'b1;
         end else begin
            pin_wr = 1'b1;
            lcd_half = 1'b0;
            lcd_bit = lcd_bit + 16'd1;
         end
      end
      return '{pin_cs, pin_wr, pin_sd, lcd_busy, refused, done};
   endfunction

   // ---------------------------------------------------------------- sender
   int             burst_left = 0;
   int             items_sent = 0;
   bit             cur_typed = 1'b0;
   pin_result_type cur_want = '0;

   task automatic send_item(input logic [1:0] op, input slsw_pkg::digit_type f,
         input slsw_pkg::digit_type s, input slsw_pkg::digit_type t,
         input slsw_pkg::digit_type u, input logic [7:0] cmd,
         input bit typed, input pin_result_type want);
      int gap;
      bit taken;
      if (burst_left == 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 300 : $urandom_range(1, 40);
      end
      req_op = op;
      req_digit_first = f;
      req_digit_second = s;
      req_digit_third = t;
      req_digit_fourth = u;
      req_command_byte = cmd;
      cur_typed = typed;
      cur_want = want;
      req_valid = 1'b1;
      do begin
         @(posedge clock);
         taken = req_ready;
         @(negedge clock);
      end while (!taken);
      burst_left--;
      items_sent++;
   endtask

   function automatic slsw_pkg::digit_type pick_digit();
      return ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) :
                                           4'($urandom_range(0, 12));
   endfunction

   // a tick carries junk in its operand fields; the block must ignore it
   task automatic send_tick();
      send_item(slsw_pkg::OP_TICK, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      burst_left = 0;
      while (pending_pins.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      pin_result_type next_pins;
      if (!reset && req_valid && req_ready) begin
         next_pins = predict_pins(req_op, req_digit_first, req_digit_second,
                                  req_digit_third, req_digit_fourth, req_command_byte);
         pending_pins.push_back(cur_typed ? cur_want : next_pins);
      end
   end

   // ---------------------------------------------------------------- receiver
   sink_mode_type sink_mode = SINK_OPEN;
   int            sink_left = 0;

   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         sink_left = $urandom_range(64, 300);
      end
      sink_left--;
      case (sink_mode)
         SINK_OPEN:   rsp_ready = 1'b1;
         SINK_THIRDS: rsp_ready = (sink_left % 3) == 0;
         SINK_COIN:   rsp_ready = 1'($urandom_range(0, 1));
         default:     rsp_ready = (sink_left % 40) < 20;
      endcase
   end

   // ---------------------------------------------------------------- checking
   int mismatches = 0;
   int results_seen = 0;
   int transfers_done = 0;
   int refusals = 0;

   task automatic log_mismatch(input string what, input pin_result_type want,
         input pin_result_type got);
      mismatches++;
      if (mismatches <= 10)
         $display({"%0t %s: expected cs_n=%b wr=%b data=%b busy=%b refused=%b done=%b,",
                   " got cs_n=%b wr=%b data=%b busy=%b refused=%b done=%b"},
                  $realtime, what, want.cs_n, want.wr_clk, want.sdata, want.busy, want.refused,
                  want.done, got.cs_n, got.wr_clk, got.sdata, got.busy, got.refused, got.done);
   endtask

   always @(posedge clock) begin
      pin_result_type got;
      pin_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_chip_select_n, rsp_write_clock, rsp_serial_data,
                rsp_busy_res, rsp_refused, rsp_done_res};
         results_seen++;
         if (got.done === 1'b1) transfers_done++;
         if (got.refused === 1'b1) refusals++;
         if (pending_pins.size() == 0) begin
            log_mismatch("result with nothing outstanding", '0, got);
         end else begin
            want = pending_pins.pop_front();
            if (got !== want) log_mismatch("pin result mismatch", want, got);
         end
      end
   end

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus
   stim_row_type directed_rows [ROWS];

   initial begin
      int         directed_items;
      int         roll;
      int         ticks;
      logic [1:0] kind;
      directed_rows = '{
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 1,   1'b1, 6'b110000},
         '{slsw_pkg::OP_SHOW,  4'd0,  4'd1,  4'd2,  4'd3,  8'h00, 1,   1'b1, 6'b110100},
         '{slsw_pkg::OP_CMD,   4'd0,  4'd0,  4'd0,  4'd0,  8'hA5, 1,   1'b1, 6'b110110},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 189, 1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd15, 4'd15, 4'd15, 4'd15, 8'hFF, 1,   1'b0, 6'b0},
         '{slsw_pkg::OP_CMD,   4'd0,  4'd0,  4'd0,  4'd0,  8'hFF, 1,   1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 10,  1'b0, 6'b0},
         '{slsw_pkg::OP_CLEAR, 4'd15, 4'd15, 4'd15, 4'd15, 8'hFF, 1,   1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 15,  1'b0, 6'b0},
         '{slsw_pkg::OP_CMD,   4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 1,   1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 25,  1'b0, 6'b0},
         '{slsw_pkg::OP_SHOW,  4'd10, 4'd11, 4'd12, 4'd13, 8'h00, 1,   1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 100, 1'b0, 6'b0},
         '{slsw_pkg::OP_SHOW,  4'd8,  4'd8,  4'd8,  4'd8,  8'h00, 1,   1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 89,  1'b0, 6'b0},
         '{slsw_pkg::OP_SHOW,  4'd15, 4'd14, 4'd9,  4'd8,  8'h00, 1,   1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 189, 1'b0, 6'b0},
         '{slsw_pkg::OP_CLEAR, 4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 1,   1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 150, 1'b0, 6'b0},
         '{slsw_pkg::OP_CMD,   4'd0,  4'd0,  4'd0,  4'd0,  8'h81, 1,   1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 125, 1'b0, 6'b0},
         '{slsw_pkg::OP_SHOW,  4'd4,  4'd5,  4'd6,  4'd7,  8'h00, 1,   1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 189, 1'b0, 6'b0},
         '{slsw_pkg::OP_CMD,   4'd0,  4'd0,  4'd0,  4'd0,  8'h5A, 1,   1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 25,  1'b0, 6'b0},
         '{slsw_pkg::OP_TICK,  4'd0,  4'd0,  4'd0,  4'd0,  8'h00, 1,   1'b0, 6'b0}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // rows with a repeat count are runs of ticks; only single rows carry a typed result
      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++)
            send_item(directed_rows[r].op, directed_rows[r].first, directed_rows[r].second,
                      directed_rows[r].third, directed_rows[r].fourth, directed_rows[r].cmd,
                      directed_rows[r].typed && directed_rows[r].reps == 1,
                      directed_rows[r].want);
      end
      directed_items = items_sent;
      wait_drained();

      while (items_sent < TOTAL_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            repeat ($urandom_range(1, 6)) send_tick();
         end else begin
            kind = (roll < 60) ? slsw_pkg::OP_CMD :
                   (roll < 88) ? slsw_pkg::OP_SHOW : slsw_pkg::OP_CLEAR;
            send_item(kind, pick_digit(), pick_digit(), pick_digit(), pick_digit(),
                      8'($urandom_range(0, 255)), 1'b0, '0);
            ticks = transfer_ticks(kind);
            for (int k = 0; k < ticks && items_sent < TOTAL_ITEMS; k++) begin
               // a stray request mid-transfer must be turned away
               if ($urandom_range(0, 99) < 3)
                  send_item(2'($urandom_range(1, 3)), 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                            1'b0, '0);
               send_tick();
            end
            if ($urandom_range(0, 19) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (pending_pins.size() != 0)
         log_mismatch("result never arrived", pending_pins[0], '0);

      $display("Sent %0d items (%0d directed), checked %0d pin results.",
               items_sent, directed_items, results_seen);
      $display("%0d transfers ran to completion, %0d requests turned away while busy.",
               transfers_done, refusals);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
